>>> design/assert_macros.svh
// Assertion macros shared by the cycle checker RTL.
// Uses the including module's i_clk and i_rst_n; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define STC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition must never be true outside reset
`define STC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

>>> design/stc_pkg.sv
// Package for the successor table cycle checker: payload types, opcodes,
// controller states and the command/status structs. No dependencies.
package stc_pkg;

    localparam int DefMaxVertices = 64;
    localparam int VtxW = 6;
    localparam int TotalW = 7;

    localparam logic [1:0] OP_ADD_VERTEX = 2'd0;
    localparam logic [1:0] OP_ADD_EDGE   = 2'd1;
    localparam logic [1:0] OP_DEL_EDGE   = 2'd2;
    localparam logic [1:0] OP_CHECK      = 2'd3;

    typedef struct packed {
        logic [1:0]      op;
        logic [VtxW-1:0] src_vertex;
        logic [VtxW-1:0] dst_vertex;
    } t_req;

    typedef struct packed {
        logic              cycle_found;
        logic [TotalW-1:0] vertex_total;
        logic              count_full;
    } t_resp;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_VTX,
        S_EDGE,
        S_DEL_CLR,
        S_DEL_DST,
        S_DEL_DSTEV,
        S_SCAN_RD,
        S_SCAN_EV,
        S_MCLR,
        S_WALK_RD,
        S_WALK_EV,
        S_RESP
    } t_state;

    // successor table write mode
    typedef enum logic [1:0] {
        SW_NONE,
        SW_SWEEP,
        SW_SET,
        SW_CLR
    } t_swr;

    // successor table read address select
    typedef enum logic [1:0] {
        SR_VTX,
        SR_DST,
        SR_PTR
    } t_srd;

    // mark table write mode
    typedef enum logic [1:0] {
        MW_NONE,
        MW_SWEEP,
        MW_VISIT
    } t_mwr;

    typedef struct packed {
        logic latch_in;
        logic ptr_clr;
        logic ptr_inc;
        t_swr succ_wr;
        t_srd succ_rd;
        t_mwr mark_wr;
        logic cnt_inc;
        logic cnt_dec;
        logic pointed_upd;
        logic dst_has_ld;
        logic walk_clr;
        logic walk_next;
        logic vtx_succ;
        logic found_set;
        logic full_set;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_table;
        logic sweep_last;
        logic scan_end;
        logic walk_last;
        logic count_zero;
        logic count_max;
        logic rd_has;
        logic mark_seen;
        logic mark_on_path;
        logic del_keep;
        logic out_busy;
    } t_stat;

endpackage

>>> design/stc_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module stc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/stc_ctrl.sv
// Controller state machine of the cycle checker.
// Depends on stc_pkg and assert_macros.svh; drives stc_datapath by t_cmd.
`include "assert_macros.svh"

module stc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic [1:0]     i_req_op,
    output logic           o_req_ready,
    input  stc_pkg::t_stat i_stat,
    output stc_pkg::t_cmd  o_cmd
);
    import stc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    case (i_req_op)
                        OP_ADD_VERTEX: n_state = S_VTX;
                        OP_ADD_EDGE:   n_state = S_EDGE;
                        OP_DEL_EDGE:   n_state = S_DEL_CLR;
                        OP_CHECK:      n_state = S_MCLR;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_VTX:       n_state = S_RESP;
            S_EDGE:      n_state = S_RESP;
            S_DEL_CLR:   n_state = i_stat.in_table ? S_DEL_DST : S_RESP;
            S_DEL_DST:   n_state = S_DEL_DSTEV;
            S_DEL_DSTEV: n_state = S_SCAN_RD;
            S_SCAN_RD:   n_state = i_stat.scan_end ? S_RESP : S_SCAN_EV;
            S_SCAN_EV:   n_state = S_SCAN_RD;
            S_MCLR: begin
                if (i_stat.sweep_last) begin
                    n_state = i_stat.count_zero ? S_RESP : S_WALK_RD;
                end
            end
            S_WALK_RD:   n_state = S_WALK_EV;
            S_WALK_EV: begin
                if (i_stat.mark_on_path) begin
                    n_state = S_RESP;
                end else if (!i_stat.mark_seen && i_stat.rd_has) begin
                    n_state = S_WALK_RD;
                end else if (i_stat.walk_last) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_WALK_RD;
                end
            end
            S_RESP: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default:     n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.succ_wr = SW_NONE;
        o_cmd.succ_rd = SR_VTX;
        o_cmd.mark_wr = MW_NONE;
        o_req_ready   = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.succ_wr = SW_SWEEP;
                o_cmd.mark_wr = MW_SWEEP;
                o_cmd.ptr_inc = 1'b1;
            end
            S_IDLE: begin
                o_req_ready    = 1'b1;
                o_cmd.latch_in = i_req_valid;
                o_cmd.ptr_clr  = 1'b1;
            end
            S_VTX: begin
                o_cmd.full_set = i_stat.count_max;
                o_cmd.cnt_inc  = !i_stat.count_max;
            end
            S_EDGE: begin
                if (i_stat.in_table) o_cmd.succ_wr = SW_SET;
            end
            S_DEL_CLR: begin
                if (i_stat.in_table) o_cmd.succ_wr = SW_CLR;
            end
            S_DEL_DST: begin
                o_cmd.succ_rd = SR_DST;
            end
            S_DEL_DSTEV: begin
                o_cmd.dst_has_ld = 1'b1;
            end
            S_SCAN_RD: begin
                o_cmd.succ_rd = SR_PTR;
                o_cmd.cnt_dec = i_stat.scan_end && !i_stat.del_keep && !i_stat.count_zero;
            end
            S_SCAN_EV: begin
                o_cmd.pointed_upd = 1'b1;
                o_cmd.ptr_inc     = 1'b1;
            end
            S_MCLR: begin
                o_cmd.mark_wr  = MW_SWEEP;
                o_cmd.ptr_inc  = 1'b1;
                o_cmd.walk_clr = i_stat.sweep_last;
            end
            S_WALK_RD: begin
                o_cmd.succ_rd = SR_VTX;
            end
            S_WALK_EV: begin
                if (i_stat.mark_on_path) begin
                    o_cmd.found_set = 1'b1;
                end else if (!i_stat.mark_seen) begin
                    o_cmd.mark_wr = MW_VISIT;
                    if (i_stat.rd_has) begin
                        o_cmd.vtx_succ = 1'b1;
                    end else begin
                        o_cmd.walk_next = !i_stat.walk_last;
                    end
                end else begin
                    o_cmd.walk_next = !i_stat.walk_last;
                end
            end
            S_RESP: begin
                o_cmd.out_load = !i_stat.out_busy;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    `STC_ASSERT(a_load_slot_free, o_cmd.out_load |-> !i_stat.out_busy, "result overwritten")
    `STC_ASSERT(a_inc_below_max, o_cmd.cnt_inc |-> !i_stat.count_max, "count overflow")
    `STC_ASSERT(a_set_in_table, (o_cmd.succ_wr == SW_SET) |-> i_stat.in_table, "bad edge write")

endmodule

>>> design/stc_datapath.sv
// Datapath of the cycle checker: successor and mark tables, counters,
// walk pointers and result register. Depends on stc_pkg, stc_ram, assert_macros.svh.
`include "assert_macros.svh"

module stc_datapath #(
    parameter int MAX_VERTICES = stc_pkg::DefMaxVertices
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  stc_pkg::t_req i_req,
    input  stc_pkg::t_cmd i_cmd,
    output stc_pkg::t_stat o_stat,
    input  logic          i_resp_ready,
    output logic          o_resp_valid,
    output stc_pkg::t_resp o_resp
);
    import stc_pkg::*;

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int SW = VtxW + 1;
    localparam int MW = IW + 1;
    localparam logic [CW-1:0] MaxCount = CW'(MAX_VERTICES);
    localparam logic [CW-1:0] LastIdx  = CW'(MAX_VERTICES - 1);

    t_req          r_req;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_walk, n_walk;
    logic [IW-1:0] r_vtx, n_vtx;
    logic          r_pointed, n_pointed;
    logic          r_dst_has, n_dst_has;
    logic          r_found, n_found;
    logic          r_full, n_full;
    t_resp         r_out;
    logic          r_out_valid, n_out_valid;

    logic [IW-1:0] src_idx, dst_idx, ptr_idx;
    logic          succ_we;
    logic [IW-1:0] succ_waddr, succ_raddr;
    logic [SW-1:0] succ_wdata, succ_rdata;
    logic          mark_we;
    logic [IW-1:0] mark_waddr;
    logic [MW-1:0] mark_wdata, mark_rdata;
    logic          rd_has, rd_match;
    logic [VtxW-1:0] rd_succ;

    assign src_idx = IW'(r_req.src_vertex);
    assign dst_idx = IW'(r_req.dst_vertex);
    assign ptr_idx = r_ptr[IW-1:0];
    assign rd_has   = succ_rdata[SW-1];
    assign rd_succ  = succ_rdata[VtxW-1:0];
    assign rd_match = rd_has && (rd_succ == r_req.dst_vertex);

    always_comb begin
        succ_we    = 1'b0;
        succ_waddr = ptr_idx;
        succ_wdata = '0;
        case (i_cmd.succ_wr)
            SW_SWEEP: succ_we = 1'b1;
            SW_SET: begin
                succ_we    = 1'b1;
                succ_waddr = src_idx;
                succ_wdata = {1'b1, r_req.dst_vertex};
            end
            SW_CLR: begin
                succ_we    = 1'b1;
                succ_waddr = src_idx;
            end
            default: succ_we = 1'b0;
        endcase
    end

    always_comb begin
        case (i_cmd.succ_rd)
            SR_DST:  succ_raddr = dst_idx;
            SR_PTR:  succ_raddr = ptr_idx;
            default: succ_raddr = r_vtx;
        endcase
    end

    always_comb begin
        mark_we    = 1'b0;
        mark_waddr = ptr_idx;
        mark_wdata = '0;
        case (i_cmd.mark_wr)
            MW_SWEEP: mark_we = 1'b1;
            MW_VISIT: begin
                mark_we    = 1'b1;
                mark_waddr = r_vtx;
                mark_wdata = {1'b1, r_walk};
            end
            default: mark_we = 1'b0;
        endcase
    end

    stc_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_succ_ram (
        .i_clk   (i_clk),
        .i_we    (succ_we),
        .i_waddr (succ_waddr),
        .i_wdata (succ_wdata),
        .i_raddr (succ_raddr),
        .o_rdata (succ_rdata)
    );

    // mark entry: visited flag plus start vertex of the walk that set it
    stc_ram #(.WIDTH(MW), .DEPTH(MAX_VERTICES)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (r_vtx),
        .o_rdata (mark_rdata)
    );

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.ptr_clr) begin
            n_ptr = '0;
        end else if (i_cmd.ptr_inc) begin
            n_ptr = r_ptr + CW'(1);
        end

        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CW'(1);
        end

        n_walk = r_walk;
        n_vtx  = r_vtx;
        if (i_cmd.walk_clr) begin
            n_walk = '0;
            n_vtx  = '0;
        end else if (i_cmd.walk_next) begin
            n_walk = r_walk + IW'(1);
            n_vtx  = r_walk + IW'(1);
        end else if (i_cmd.vtx_succ) begin
            n_vtx = IW'(rd_succ);
        end

        n_pointed = r_pointed;
        if (i_cmd.latch_in) begin
            n_pointed = 1'b0;
        end else if (i_cmd.pointed_upd) begin
            n_pointed = r_pointed || rd_match;
        end

        n_dst_has = i_cmd.dst_has_ld ? rd_has : r_dst_has;
        n_found   = i_cmd.latch_in ? 1'b0 : (r_found || i_cmd.found_set);
        n_full    = i_cmd.latch_in ? 1'b0 : (r_full || i_cmd.full_set);

        n_out_valid = r_out_valid;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_resp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_count     <= '0;
            r_walk      <= '0;
            r_vtx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ptr       <= n_ptr;
            r_count     <= n_count;
            r_walk      <= n_walk;
            r_vtx       <= n_vtx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_req <= i_req;
        end
        r_pointed <= n_pointed;
        r_dst_has <= n_dst_has;
        r_found   <= n_found;
        r_full    <= n_full;
        if (i_cmd.out_load) begin
            r_out.cycle_found  <= r_found;
            r_out.vertex_total <= TotalW'(r_count);
            r_out.count_full   <= r_full;
        end
    end

    assign o_stat.in_table     = (int'(r_req.src_vertex) < MAX_VERTICES) &&
                                 (int'(r_req.dst_vertex) < MAX_VERTICES);
    assign o_stat.sweep_last   = (r_ptr == LastIdx);
    assign o_stat.scan_end     = (r_ptr == r_count);
    assign o_stat.walk_last    = ((CW'(r_walk) + CW'(1)) == r_count);
    assign o_stat.count_zero   = (r_count == '0);
    assign o_stat.count_max    = (r_count == MaxCount);
    assign o_stat.rd_has       = rd_has;
    assign o_stat.mark_seen    = mark_rdata[MW-1];
    assign o_stat.mark_on_path = mark_rdata[MW-1] && (mark_rdata[IW-1:0] == r_walk);
    assign o_stat.del_keep     = r_pointed || r_dst_has;
    assign o_stat.out_busy     = r_out_valid && !i_resp_ready;

    assign o_resp_valid = r_out_valid;
    assign o_resp       = r_out;

    `STC_ASSERT(a_count_bound, r_count <= MaxCount, "vertex count above table size")
    `STC_ASSERT_NEVER(a_vtx_range, int'(r_vtx) >= MAX_VERTICES, "walk vertex out of table")

endmodule

>>> design/successor_table_cycle_check_top.sv
// Top level of the successor table cycle checker.
// Depends on stc_pkg, stc_ctrl and stc_datapath.
//
// Request channel (i_req_valid/o_req_ready, i_req): op, src_vertex, dst_vertex.
// Response channel (o_resp_valid/i_resp_ready, o_resp): one response per request
// with cycle_found, vertex_total and count_full.
// One request is worked on at a time; steps from acceptance to response valid:
//   add vertex, add edge: an update state, then the response state
//   delete edge: entry clear, destination read, one table read per vertex in use
//   check: mark table clear sweep, then one table read per walk step,
//     visits <= MAX_VERTICES + count
// The next request can be taken as soon as the response is registered, even
// while that response still waits in the output register.
// Reset: synchronous, active low. After reset both tables are cleared in a
// sweep over all MAX_VERTICES entries while o_req_ready stays low.
// Receiver stall: the response holds in the output register; a later response
// waits in the controller until the register frees up.
module successor_table_cycle_check_top #(
    parameter int MAX_VERTICES = stc_pkg::DefMaxVertices
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  stc_pkg::t_req  i_req,
    output logic           o_resp_valid,
    input  logic           i_resp_ready,
    output stc_pkg::t_resp o_resp
);
    import stc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    stc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_op    (i_req.op),
        .o_req_ready (o_req_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    stc_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_resp_ready (i_resp_ready),
        .o_resp_valid (o_resp_valid),
        .o_resp       (o_resp)
    );

endmodule
